[src/tvme_pkg.sv]
// shared types, codes and helpers for the tagged varint message encoder
package tvme_pkg;

    localparam int HOLD_DEPTH = 4;
    localparam int ID_W       = 32;
    localparam int VAL_W      = 64;
    localparam int CODE_W     = 3;
    localparam int OP_W       = 4;
    localparam int EW_W       = 2;
    localparam int BYTE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 112;
    localparam int M_USER_W   = 2;

    localparam logic [ID_W-1:0]   ID_MAX_RESET    = 32'hFFFF_FFFF;
    localparam logic [CODE_W-1:0] SEQ_START_RESET = 3'd6;
    localparam logic [CODE_W-1:0] SEQ_END_RESET   = 3'd7;

    localparam logic [CFG_IDX_W-1:0] CFG_ID_MAX    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_START = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_END   = 2'd2;

    localparam logic [OP_W-1:0] OP_FIELD_U  = 4'd0;
    localparam logic [OP_W-1:0] OP_FIELD_S  = 4'd1;
    localparam logic [OP_W-1:0] OP_ELEM_U   = 4'd2;
    localparam logic [OP_W-1:0] OP_ELEM_S   = 4'd3;
    localparam logic [OP_W-1:0] OP_RAW      = 4'd4;
    localparam logic [OP_W-1:0] OP_SEQ      = 4'd5;
    localparam logic [OP_W-1:0] OP_LAZY     = 4'd6;
    localparam logic [OP_W-1:0] OP_END      = 4'd7;
    localparam logic [OP_W-1:0] OP_END_KEEP = 4'd8;

    localparam logic [EW_W-1:0] EW_8  = 2'd0;
    localparam logic [EW_W-1:0] EW_16 = 2'd1;
    localparam logic [EW_W-1:0] EW_32 = 2'd2;

    typedef enum logic [1:0] {
        LOAD_NONE = 2'd0,
        LOAD_HELD = 2'd1,
        LOAD_HDR  = 2'd2,
        LOAD_PAY  = 2'd3
    } load_sel_t;

    typedef enum logic [1:0] {
        HDR_FIELD = 2'd0,
        HDR_START = 2'd1,
        HDR_END   = 2'd2
    } hdr_sel_t;

    typedef enum logic [1:0] {
        EMIT_NONE   = 2'd0,
        EMIT_VARINT = 2'd1,
        EMIT_RAW    = 2'd2,
        EMIT_CLOSE  = 2'd3
    } emit_t;

    typedef struct packed {
        logic      latch;
        logic      push;
        logic      pop;
        logic      held_clr;
        logic      idx_clr;
        logic      idx_inc;
        load_sel_t load_sel;
        hdr_sel_t  hdr_sel;
        emit_t     emit;
        logic      last;
        logic      err;
    } cmd_t;

    typedef struct packed {
        logic id_ok;
        logic wt_seq;
        logic held_empty;
        logic held_full;
        logic commit_last;
        logic vreg_last;
        logic out_free;
    } sts_t;

    function automatic logic [VAL_W-1:0] zigzag(input logic [VAL_W-1:0] v);
        return {v[VAL_W-2:0], 1'b0} ^ {VAL_W{v[VAL_W-1]}};
    endfunction

endpackage

[src/tvme_ctrl.sv]
// controller state machine: sequences held headers, header, payload, raw and closing results
module tvme_ctrl
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [tvme_pkg::OP_W-1:0]    in_op,
    input  tvme_pkg::sts_t               sts,
    output tvme_pkg::cmd_t               cmd
);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_DISPATCH = 7'b0000010,
        S_COMMIT   = 7'b0000100,
        S_HDR      = 7'b0001000,
        S_PAY      = 7'b0010000,
        S_RAW      = 7'b0100000,
        S_CLOSE    = 7'b1000000
    } state_t;

    state_t                      state_reg, state_next;
    logic [tvme_pkg::OP_W-1:0]   op_reg, op_next;
    logic                        do_hdr_reg, do_hdr_next;
    logic                        do_pay_reg, do_pay_next;
    logic                        err_reg, err_next;
    tvme_pkg::hdr_sel_t          hdr_sel_reg, hdr_sel_next;

    logic                        c_disp, h_disp, p_disp, e_disp;
    tvme_pkg::hdr_sel_t          hs_disp;

    assign s_tready = (state_reg == S_IDLE);

    // item decode, used in the dispatch cycle
    always_comb
    begin
        c_disp  = 1'b0;
        h_disp  = 1'b0;
        p_disp  = 1'b0;
        e_disp  = 1'b0;
        hs_disp = tvme_pkg::HDR_START;
        case (op_reg)
            tvme_pkg::OP_FIELD_U, tvme_pkg::OP_FIELD_S:
            begin
                if (!sts.id_ok)
                begin
                    e_disp = 1'b1;
                end
                else
                begin
                    c_disp  = !sts.held_empty && !sts.wt_seq;
                    h_disp  = 1'b1;
                    p_disp  = 1'b1;
                    hs_disp = tvme_pkg::HDR_FIELD;
                end
            end
            tvme_pkg::OP_ELEM_U, tvme_pkg::OP_ELEM_S:
            begin
                p_disp = 1'b1;
            end
            tvme_pkg::OP_SEQ:
            begin
                c_disp = !sts.held_empty;
                h_disp = sts.id_ok;
                e_disp = !sts.id_ok;
            end
            tvme_pkg::OP_LAZY:
            begin
                if (!sts.id_ok)
                begin
                    e_disp = 1'b1;
                end
                else if (sts.held_full)
                begin
                    c_disp = 1'b1;
                    h_disp = 1'b1;
                end
            end
            tvme_pkg::OP_END:
            begin
                if (sts.held_empty)
                begin
                    h_disp  = 1'b1;
                    hs_disp = tvme_pkg::HDR_END;
                end
            end
            tvme_pkg::OP_END_KEEP:
            begin
                c_disp  = !sts.held_empty;
                h_disp  = 1'b1;
                hs_disp = tvme_pkg::HDR_END;
            end
            default:
            begin
                c_disp = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        do_hdr_next  = do_hdr_reg;
        do_pay_next  = do_pay_reg;
        err_next     = err_reg;
        hdr_sel_next = hdr_sel_reg;
        cmd          = '0;
        cmd.load_sel = tvme_pkg::LOAD_NONE;
        cmd.hdr_sel  = hdr_sel_reg;
        cmd.emit     = tvme_pkg::EMIT_NONE;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.latch  = 1'b1;
                    op_next    = in_op;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                do_hdr_next  = h_disp;
                do_pay_next  = p_disp;
                err_next     = e_disp;
                hdr_sel_next = hs_disp;
                cmd.hdr_sel  = hs_disp;
                cmd.push     = (op_reg == tvme_pkg::OP_LAZY) && sts.id_ok && !sts.held_full;
                cmd.pop      = (op_reg == tvme_pkg::OP_END) && !sts.held_empty;
                if (op_reg == tvme_pkg::OP_RAW)
                begin
                    state_next = S_RAW;
                end
                else if (c_disp)
                begin
                    cmd.idx_clr  = 1'b1;
                    cmd.load_sel = tvme_pkg::LOAD_HELD;
                    state_next   = S_COMMIT;
                end
                else if (h_disp)
                begin
                    cmd.load_sel = tvme_pkg::LOAD_HDR;
                    state_next   = S_HDR;
                end
                else if (p_disp)
                begin
                    cmd.load_sel = tvme_pkg::LOAD_PAY;
                    state_next   = S_PAY;
                end
                else
                begin
                    state_next = S_CLOSE;
                end
            end
            S_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = tvme_pkg::EMIT_VARINT;
                    if (sts.vreg_last)
                    begin
                        if (!sts.commit_last)
                        begin
                            cmd.idx_inc  = 1'b1;
                            cmd.load_sel = tvme_pkg::LOAD_HELD;
                        end
                        else
                        begin
                            cmd.held_clr = 1'b1;
                            if (do_hdr_reg)
                            begin
                                cmd.load_sel = tvme_pkg::LOAD_HDR;
                                state_next   = S_HDR;
                            end
                            else
                            begin
                                state_next = S_CLOSE;
                            end
                        end
                    end
                end
            end
            S_HDR:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = tvme_pkg::EMIT_VARINT;
                    cmd.last = !do_pay_reg;
                    if (sts.vreg_last)
                    begin
                        if (do_pay_reg)
                        begin
                            cmd.load_sel = tvme_pkg::LOAD_PAY;
                            state_next   = S_PAY;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            S_PAY:
            begin
                if (sts.out_free)
                begin
                    cmd.emit = tvme_pkg::EMIT_VARINT;
                    cmd.last = 1'b1;
                    if (sts.vreg_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_RAW:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = tvme_pkg::EMIT_RAW;
                    cmd.last   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_CLOSE:
            begin
                if (sts.out_free)
                begin
                    cmd.emit   = tvme_pkg::EMIT_CLOSE;
                    cmd.last   = 1'b1;
                    cmd.err    = err_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            op_reg      <= '0;
            do_hdr_reg  <= 1'b0;
            do_pay_reg  <= 1'b0;
            err_reg     <= 1'b0;
            hdr_sel_reg <= tvme_pkg::HDR_START;
        end
        else
        begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            do_hdr_reg  <= do_hdr_next;
            do_pay_reg  <= do_pay_next;
            err_reg     <= err_next;
            hdr_sel_reg <= hdr_sel_next;
        end
    end

endmodule

[src/tvme_dp.sv]
// datapath: config registers, held id stack, varint shifter and output register
module tvme_dp
#(
    parameter int HOLD_DEPTH = tvme_pkg::HOLD_DEPTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [tvme_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tvme_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [tvme_pkg::OP_W-1:0]         in_op,
    input  logic [tvme_pkg::ID_W-1:0]         in_field_id,
    input  logic [tvme_pkg::CODE_W-1:0]       in_wire_type,
    input  logic [tvme_pkg::VAL_W-1:0]        in_value,
    input  logic [tvme_pkg::EW_W-1:0]         in_element_width,
    input  tvme_pkg::cmd_t                    cmd,
    output tvme_pkg::sts_t                    sts,
    input  logic                              m_tready,
    output logic                              m_tvalid,
    output logic [tvme_pkg::BYTE_W-1:0]       out_byte,
    output logic                              byte_valid,
    output logic                              status,
    output logic                              last
);

    localparam int IW = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CW = $clog2(HOLD_DEPTH + 1);
    localparam int VW = tvme_pkg::VAL_W;
    localparam int IDW = tvme_pkg::ID_W;
    localparam int CDW = tvme_pkg::CODE_W;

    logic [IDW-1:0]  id_max_reg;
    logic [CDW-1:0]  seq_start_reg;
    logic [CDW-1:0]  seq_end_reg;

    logic [IDW-1:0]  held_ids [HOLD_DEPTH];
    logic [CW-1:0]   held_count_reg;
    logic [IW-1:0]   idx_reg;
    logic [IW-1:0]   idx_next;

    logic [IDW-1:0]  id_reg;
    logic [CDW-1:0]  wt_reg;
    logic [VW-1:0]   pay_reg;
    logic            id_ok_reg;
    logic            wt_seq_reg;
    logic [VW-1:0]   vreg_reg;

    logic [VW-1:0]   pay_calc;
    logic [VW-1:0]   elem_bits;
    logic [VW-1:0]   hdr_word;
    logic [VW-1:0]   held_word;
    logic            vlast;

    logic            out_valid_reg;
    logic [tvme_pkg::BYTE_W-1:0] out_byte_reg;
    logic            out_bv_reg;
    logic            out_status_reg;
    logic            out_last_reg;

    // element payload: truncate to width, optional sign extension
    always_comb
    begin
        case (in_element_width)
            tvme_pkg::EW_8:
                elem_bits = {{(VW-8){in_value[7] & in_op[0]}}, in_value[7:0]};
            tvme_pkg::EW_16:
                elem_bits = {{(VW-16){in_value[15] & in_op[0]}}, in_value[15:0]};
            tvme_pkg::EW_32:
                elem_bits = {{(VW-32){in_value[31] & in_op[0]}}, in_value[31:0]};
            default:
                elem_bits = in_value;
        endcase
    end

    always_comb
    begin
        case (in_op)
            tvme_pkg::OP_FIELD_S: pay_calc = tvme_pkg::zigzag(in_value);
            tvme_pkg::OP_ELEM_U:  pay_calc = elem_bits;
            tvme_pkg::OP_ELEM_S:  pay_calc = tvme_pkg::zigzag(elem_bits);
            default:              pay_calc = in_value;
        endcase
    end

    always_comb
    begin
        case (cmd.hdr_sel)
            tvme_pkg::HDR_FIELD: hdr_word = {{(VW-IDW-CDW){1'b0}}, id_reg, wt_reg};
            tvme_pkg::HDR_START: hdr_word = {{(VW-IDW-CDW){1'b0}}, id_reg, seq_start_reg};
            default:             hdr_word = {{(VW-CDW){1'b0}}, seq_end_reg};
        endcase
    end

    always_comb
    begin
        if (cmd.idx_clr)
            idx_next = '0;
        else if (cmd.idx_inc)
            idx_next = idx_reg + IW'(1);
        else
            idx_next = idx_reg;
    end

    assign held_word = {{(VW-IDW-CDW){1'b0}}, held_ids[idx_next], seq_start_reg};
    assign vlast     = (vreg_reg[VW-1:7] == '0);

    assign sts.id_ok       = id_ok_reg;
    assign sts.wt_seq      = wt_seq_reg;
    assign sts.held_empty  = (held_count_reg == '0);
    assign sts.held_full   = (held_count_reg == CW'(HOLD_DEPTH));
    assign sts.commit_last = ((CW'(idx_reg) + CW'(1)) == held_count_reg);
    assign sts.vreg_last   = vlast;
    assign sts.out_free    = !out_valid_reg || m_tready;

    // configuration, held count and output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_max_reg     <= tvme_pkg::ID_MAX_RESET;
            seq_start_reg  <= tvme_pkg::SEQ_START_RESET;
            seq_end_reg    <= tvme_pkg::SEQ_END_RESET;
            held_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tvme_pkg::CFG_ID_MAX:    id_max_reg    <= cfg_data[IDW-1:0];
                    tvme_pkg::CFG_SEQ_START: seq_start_reg <= cfg_data[CDW-1:0];
                    tvme_pkg::CFG_SEQ_END:   seq_end_reg   <= cfg_data[CDW-1:0];
                    default:                 id_max_reg    <= id_max_reg;
                endcase
            end
            if (cmd.held_clr)
                held_count_reg <= '0;
            else if (cmd.push)
                held_count_reg <= held_count_reg + CW'(1);
            else if (cmd.pop)
                held_count_reg <= held_count_reg - CW'(1);
            if (cmd.emit != tvme_pkg::EMIT_NONE)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // held ids, item, shifter and output data registers
    always_ff @(posedge clk)
    begin
        if (cmd.push)
            held_ids[held_count_reg[IW-1:0]] <= id_reg;
        idx_reg <= idx_next;
        if (cmd.latch)
        begin
            id_reg     <= in_field_id;
            wt_reg     <= in_wire_type;
            pay_reg    <= pay_calc;
            id_ok_reg  <= (in_field_id <= id_max_reg);
            wt_seq_reg <= (in_wire_type == seq_start_reg) || (in_wire_type == seq_end_reg);
        end
        case (cmd.load_sel)
            tvme_pkg::LOAD_HELD: vreg_reg <= held_word;
            tvme_pkg::LOAD_HDR:  vreg_reg <= hdr_word;
            tvme_pkg::LOAD_PAY:  vreg_reg <= pay_reg;
            default:
            begin
                if (cmd.emit == tvme_pkg::EMIT_VARINT)
                    vreg_reg <= {7'd0, vreg_reg[VW-1:7]};
            end
        endcase
        case (cmd.emit)
            tvme_pkg::EMIT_VARINT:
            begin
                out_byte_reg   <= {!vlast, vreg_reg[6:0]};
                out_bv_reg     <= 1'b1;
                out_status_reg <= 1'b0;
                out_last_reg   <= cmd.last & vlast;
            end
            tvme_pkg::EMIT_RAW:
            begin
                out_byte_reg   <= pay_reg[7:0];
                out_bv_reg     <= 1'b1;
                out_status_reg <= 1'b0;
                out_last_reg   <= cmd.last;
            end
            tvme_pkg::EMIT_CLOSE:
            begin
                out_byte_reg   <= '0;
                out_bv_reg     <= 1'b0;
                out_status_reg <= cmd.err;
                out_last_reg   <= cmd.last;
            end
            default:
            begin
                out_byte_reg <= out_byte_reg;
            end
        endcase
    end

    assign m_tvalid   = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = out_bv_reg;
    assign status     = out_status_reg;
    assign last       = out_last_reg;

endmodule

[src/tagged_varint_message_encoder.sv]
// top level of the tagged varint message encoder
// accept in idle, decode in dispatch, then the first result enters the output register
// an item gives 1 to 35 results, one per cycle unless the output stalls; the next item waits
// held headers are sent first, 35-bit headers take up to 5 bytes, payloads up to 10 bytes
// output backpressure stalls the byte sequencer; one finished result may wait in the output register
// reset clears the held id count and the output valid flag, and loads config defaults
module tagged_varint_message_encoder
#(
    parameter int HOLD_DEPTH = tvme_pkg::HOLD_DEPTH
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // operation, field_id, wire_type, value, element_width
    input  logic [tvme_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // out_byte
    output logic [tvme_pkg::BYTE_W-1:0]       m_tdata,
    // byte_valid, status
    output logic [tvme_pkg::M_USER_W-1:0]     m_tuser,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic [tvme_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tvme_pkg::CFG_DATA_W-1:0]   cfg_data
);

    tvme_pkg::cmd_t cmd;
    tvme_pkg::sts_t sts;

    logic [tvme_pkg::OP_W-1:0]   in_op;
    logic [tvme_pkg::ID_W-1:0]   in_field_id;
    logic [tvme_pkg::CODE_W-1:0] in_wire_type;
    logic [tvme_pkg::VAL_W-1:0]  in_value;
    logic [tvme_pkg::EW_W-1:0]   in_element_width;
    logic                        byte_valid;
    logic                        status;

    assign in_op            = s_tdata[3:0];
    assign in_field_id      = s_tdata[35:4];
    assign in_wire_type     = s_tdata[38:36];
    assign in_value         = s_tdata[102:39];
    assign in_element_width = s_tdata[104:103];

    assign m_tuser = {status, byte_valid};

    tvme_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_op    (in_op),
        .sts      (sts),
        .cmd      (cmd)
    );

    tvme_dp
    #(
        .HOLD_DEPTH (HOLD_DEPTH)
    )
    u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_op            (in_op),
        .in_field_id      (in_field_id),
        .in_wire_type     (in_wire_type),
        .in_value         (in_value),
        .in_element_width (in_element_width),
        .cmd              (cmd),
        .sts              (sts),
        .m_tready         (m_tready),
        .m_tvalid         (m_tvalid),
        .out_byte         (m_tdata),
        .byte_valid       (byte_valid),
        .status           (status),
        .last             (m_tlast)
    );

endmodule

[test/tvme_stream_checker.sv]
// stream checker for the tagged varint message encoder: predicts every output transfer and compares
`timescale 1ns / 1ps

module tvme_stream_checker
    import tvme_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // operation, field_id, wire_type, value, element_width
    input  logic [S_DATA_W-1:0]   s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // out_byte
    input  logic [BYTE_W-1:0]     m_tdata,
    // byte_valid, status
    input  logic [M_USER_W-1:0]   m_tuser,
    input  logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    beats_checked,
    output int                    rejections
);

    localparam int MAX_BEATS   = 35;
    localparam int MAX_PRINTED = 40;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic              err;
        logic              last;
    } stream_beat_t;

    stream_beat_t expected_bytes[$];
    stream_beat_t item_beats[$];

    logic [ID_W-1:0]   held_ids [HOLD_DEPTH];
    int                held_count;
    logic [ID_W-1:0]   id_limit;
    logic [CODE_W-1:0] start_code;
    logic [CODE_W-1:0] end_code;

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        fail_count++;
        if (fail_count <= MAX_PRINTED)
            $display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    function automatic logic [VAL_W-1:0] zz_map(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] sign_mask;
        sign_mask = v[VAL_W-1] ? '1 : '0;
        return (v << 1) ^ sign_mask;
    endfunction

    function automatic logic [VAL_W-1:0] element_payload(input logic [VAL_W-1:0] v,
                                                         input logic [EW_W-1:0] ew,
                                                         input logic sgn);
        logic [VAL_W-1:0] r;
        case (ew)
            EW_8:    r = sgn ? {{56{v[7]}}, v[7:0]} : {56'd0, v[7:0]};
            EW_16:   r = sgn ? {{48{v[15]}}, v[15:0]} : {48'd0, v[15:0]};
            EW_32:   r = sgn ? {{32{v[31]}}, v[31:0]} : {32'd0, v[31:0]};
            default: r = v;
        endcase
        return sgn ? zz_map(r) : r;
    endfunction

    task automatic emit_beat(input logic [BYTE_W-1:0] b, input logic v, input logic e);
        stream_beat_t beat;
        beat.data  = b;
        beat.valid = v;
        beat.err   = e;
        beat.last  = 1'b0;
        if (item_beats.size() < MAX_BEATS)
            item_beats.push_back(beat);
    endtask

    task automatic emit_varint(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] rest;
        logic [6:0]       low7;
        rest = v;
        do
        begin
            low7 = rest[6:0];
            rest = rest >> 7;
            emit_beat({rest != 0, low7}, 1'b1, 1'b0);
        end
        while (rest != 0);
    endtask

    task automatic emit_header(input logic [ID_W-1:0] id, input logic [CODE_W-1:0] code);
        emit_varint({29'd0, id, code});
    endtask

    task automatic flush_held;
        for (int i = 0; i < held_count && i < HOLD_DEPTH; i++)
            emit_header(held_ids[i], start_code);
        held_count = 0;
    endtask

    task automatic predict_item(input logic [S_DATA_W-1:0] word);
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   id;
        logic [CODE_W-1:0] wt;
        logic [VAL_W-1:0]  val;
        logic [EW_W-1:0]   ew;
        logic              rejected;
        stream_beat_t      closing;
        op       = word[3:0];
        id       = word[35:4];
        wt       = word[38:36];
        val      = word[102:39];
        ew       = word[104:103];
        rejected = 1'b0;
        item_beats.delete();
        case (op)
            OP_FIELD_U, OP_FIELD_S:
            begin
                if (id > id_limit)
                    rejected = 1'b1;
                else
                begin
                    // a header typed as a sequence code leaves held headers alone
                    if (held_count != 0 && wt != start_code && wt != end_code)
                        flush_held();
                    emit_header(id, wt);
                    emit_varint(op == OP_FIELD_S ? zz_map(val) : val);
                end
            end
            OP_ELEM_U, OP_ELEM_S:
                emit_varint(element_payload(val, ew, op == OP_ELEM_S));
            OP_RAW:
                emit_beat(val[7:0], 1'b1, 1'b0);
            OP_SEQ:
            begin
                flush_held();
                if (id > id_limit)
                    rejected = 1'b1;
                else
                    emit_header(id, start_code);
            end
            OP_LAZY:
            begin
                if (id > id_limit)
                    rejected = 1'b1;
                else if (held_count < HOLD_DEPTH)
                begin
                    held_ids[held_count] = id;
                    held_count++;
                end
                else
                begin
                    flush_held();
                    emit_header(id, start_code);
                end
            end
            OP_END:
            begin
                if (held_count != 0)
                    held_count--;
                else
                    emit_header('0, end_code);
            end
            OP_END_KEEP:
            begin
                flush_held();
                emit_header('0, end_code);
            end
            default: ;
        endcase
        if (rejected)
        begin
            emit_beat('0, 1'b0, 1'b1);
            rejections++;
        end
        else if (item_beats.size() == 0)
            emit_beat('0, 1'b0, 1'b0);
        closing = item_beats[item_beats.size()-1];
        closing.last = 1'b1;
        item_beats[item_beats.size()-1] = closing;
        foreach (item_beats[i])
            expected_bytes.push_back(item_beats[i]);
    endtask

    task automatic check_beat;
        stream_beat_t want;
        beats_checked++;
        if (expected_bytes.size() == 0)
            report_mismatch("unexpected transfer", 64'({m_tlast, m_tuser, m_tdata}), '0);
        else
        begin
            want = expected_bytes.pop_front();
            if (m_tdata !== want.data)
                report_mismatch("out_byte", 64'(m_tdata), 64'(want.data));
            if (m_tuser[0] !== want.valid)
                report_mismatch("byte_valid", 64'(m_tuser[0]), 64'(want.valid));
            if (m_tuser[1] !== want.err)
                report_mismatch("status", 64'(m_tuser[1]), 64'(want.err));
            if (m_tlast !== want.last)
                report_mismatch("last", 64'(m_tlast), 64'(want.last));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            id_limit      = ID_MAX_RESET;
            start_code    = SEQ_START_RESET;
            end_code      = SEQ_END_RESET;
            held_count    = 0;
            fail_count    = 0;
            pending       = 0;
            beats_checked = 0;
            rejections    = 0;
            expected_bytes.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_ID_MAX:    id_limit   = cfg_data[ID_W-1:0];
                    CFG_SEQ_START: start_code = cfg_data[CODE_W-1:0];
                    CFG_SEQ_END:   end_code   = cfg_data[CODE_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_item(s_tdata);
            if (m_tvalid && m_tready)
                check_beat();
            pending = expected_bytes.size();
        end
    end

endmodule

[test/tb_tagged_varint_message_encoder.sv]
// testbench top for the tagged varint message encoder: stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module tb_tagged_varint_message_encoder;
    import tvme_pkg::*;

    localparam int CYCLE_LIMIT      = 600000;
    localparam int PHASES           = 6;
    localparam int RANDOM_PER_PHASE = 32;
    localparam int TAIL_CYCLES      = 12;

    localparam logic [OP_W-1:0]      OP_UNUSED_LO = 4'd9;
    localparam logic [OP_W-1:0]      OP_UNUSED_HI = 4'd15;
    localparam logic [EW_W-1:0]      EW_64        = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [BYTE_W-1:0]     m_tdata;
    logic [M_USER_W-1:0]   m_tuser;
    logic                  m_tlast;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int pending;
    int beats_checked;
    int rejections;

    int items_sent;
    int directed_items;
    int random_items;
    int settings_count;
    int burst_left;
    int open_depth;
    int cycle_no;

    logic [ID_W-1:0]   cur_id_max;
    logic [CODE_W-1:0] cur_start;
    logic [CODE_W-1:0] cur_end;

    tagged_varint_message_encoder dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tvme_stream_checker u_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .fail_count    (fail_count),
        .pending       (pending),
        .beats_checked (beats_checked),
        .rejections    (rejections)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (cycle_no == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_no);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // receiver back-pressure: free-running, stalling, sparse and mostly-ready stretches
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            case ((cycle_no / 128) % 4)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= (cycle_no % 4) == 0;
                default: m_tready <= $urandom_range(0, 7) != 0;
            endcase
        end
    end

    task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                             input logic [CODE_W-1:0] wt, input logic [VAL_W-1:0] val,
                             input logic [EW_W-1:0] ew);
        int gap;
        s_tdata  <= {7'd0, ew, val, wt, id, op};
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // hold the sender until every predicted transfer has been seen
    task automatic drain_outputs;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic program_regs(input logic [ID_W-1:0] idmax, input logic [CODE_W-1:0] st,
                                input logic [CODE_W-1:0] en, input logic poke_unused);
        logic [31:0] junk;
        drain_outputs();
        junk = $urandom;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ID_MAX;
        cfg_data  <= idmax;
        @(posedge clk);
        cfg_index <= CFG_SEQ_START;
        cfg_data  <= {junk[31:3], st};
        @(posedge clk);
        cfg_index <= CFG_SEQ_END;
        cfg_data  <= {~junk[31:3], en};
        @(posedge clk);
        if (poke_unused)
        begin
            cfg_index <= CFG_UNUSED;
            cfg_data  <= $urandom;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        cur_id_max = idmax;
        cur_start  = st;
        cur_end    = en;
        settings_count++;
    endtask

    task automatic send_random;
        int                pick;
        logic [OP_W-1:0]   op;
        logic [ID_W-1:0]   id;
        logic [CODE_W-1:0] wt;
        logic [VAL_W-1:0]  val;
        logic [EW_W-1:0]   ew;
        pick = $urandom_range(0, 99);
        if (pick < 3)
            op = OP_W'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        else if (pick < 20 && open_depth < 6)
        begin
            op = OP_LAZY;
            open_depth++;
        end
        else if (pick < 25)
            op = OP_SEQ;
        else if (pick < 43 && (open_depth > 0 || $urandom_range(0, 3) == 0))
        begin
            op = ($urandom_range(0, 4) == 0) ? OP_END_KEEP : OP_END;
            if (open_depth > 0)
                open_depth--;
        end
        else if (pick < 68)
            op = $urandom_range(0, 1) ? OP_FIELD_S : OP_FIELD_U;
        else if (pick < 90)
            op = $urandom_range(0, 1) ? OP_ELEM_S : OP_ELEM_U;
        else
            op = OP_RAW;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: id = ID_W'($urandom_range(0, 31));
            4:          id = cur_id_max;
            5:          id = cur_id_max + 1;
            6:          id = '1;
            default:    id = $urandom;
        endcase
        case ($urandom_range(0, 5))
            0:       wt = cur_start;
            1:       wt = cur_end;
            default: wt = CODE_W'($urandom_range(0, 7));
        endcase
        val = {$urandom, $urandom} >> $urandom_range(0, 63);
        if ($urandom_range(0, 3) == 0)
            val = ~val;
        ew = EW_W'($urandom_range(0, 3));
        if (op <= OP_END_KEEP)
            random_items++;
        send_item(op, id, wt, val, ew);
    endtask

    initial
    begin
        int phase_start;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        items_sent     = 0;
        random_items   = 0;
        settings_count = 1;
        open_depth     = 0;
        burst_left     = $urandom_range(1, 16);
        cur_id_max     = ID_MAX_RESET;
        cur_start      = SEQ_START_RESET;
        cur_end        = SEQ_END_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // field, element and raw extremes under the reset settings
        send_item(OP_FIELD_U, 32'd0, 3'd0, 64'd0, EW_8);
        send_item(OP_FIELD_U, 32'hFFFF_FFFF, 3'd7, '1, EW_64);
        send_item(OP_FIELD_S, 32'd1, 3'd0, '1, EW_8);
        send_item(OP_FIELD_S, 32'd2, 3'd1, 64'h8000_0000_0000_0000, EW_16);
        send_item(OP_ELEM_U, 32'd0, 3'd0, '1, EW_8);
        send_item(OP_ELEM_U, 32'd0, 3'd0, 64'h0123_4567_89AB_CDEF, EW_32);
        send_item(OP_ELEM_S, 32'd0, 3'd0, 64'hAAAA_AAAA_AAAA_AA80, EW_8);
        send_item(OP_ELEM_S, 32'd0, 3'd0, 64'h5555_5555_5555_8000, EW_16);
        send_item(OP_ELEM_S, 32'd0, 3'd0, 64'h8000_0000_0000_0000, EW_64);
        send_item(OP_RAW, 32'hFFFF_FFFF, 3'd7, 64'hFFFF_FFFF_FFFF_FF00, EW_64);
        send_item(OP_RAW, 32'd0, 3'd0, 64'h0000_0000_0000_00FF, EW_8);
        // fill the held stack, then content that must not commit it
        send_item(OP_LAZY, 32'd10, 3'd0, 64'd0, EW_8);
        send_item(OP_LAZY, 32'd300, 3'd0, 64'd0, EW_8);
        send_item(OP_LAZY, 32'hFFFF_FFFF, 3'd0, 64'd0, EW_8);
        send_item(OP_LAZY, 32'd1, 3'd0, 64'd0, EW_8);
        send_item(OP_ELEM_U, 32'd0, 3'd0, 64'd300, EW_64);
        send_item(OP_FIELD_U, 32'd4, SEQ_START_RESET, 64'd1, EW_8);
        send_item(OP_FIELD_S, 32'd5, SEQ_END_RESET, 64'd2, EW_8);
        // lazy begin on a full stack commits everything plus its own header
        send_item(OP_LAZY, 32'd5, 3'd0, 64'd0, EW_8);
        send_item(OP_LAZY, 32'd20, 3'd0, 64'd0, EW_8);
        send_item(OP_END, 32'd0, 3'd0, 64'd0, EW_8);
        send_item(OP_END, 32'd0, 3'd0, 64'd0, EW_8);
        send_item(OP_LAZY, 32'd21, 3'd0, 64'd0, EW_8);
        send_item(OP_SEQ, 32'd9, 3'd0, 64'd0, EW_8);
        send_item(OP_LAZY, 32'd7, 3'd0, 64'd0, EW_8);
        send_item(OP_FIELD_S, 32'd8, 3'd3, 64'hFFFF_FFFF_FFFF_FF80, EW_8);
        send_item(OP_END_KEEP, 32'd0, 3'd0, 64'd0, EW_8);
        send_item(OP_UNUSED_HI, '1, '1, '1, EW_64);

        // id rejection on fields, lazy and eager begins
        program_regs(32'd100, SEQ_START_RESET, SEQ_END_RESET, 1'b1);
        send_item(OP_FIELD_U, 32'd101, 3'd2, 64'd5, EW_8);
        send_item(OP_LAZY, 32'd50, 3'd0, 64'd0, EW_8);
        send_item(OP_LAZY, 32'd200, 3'd0, 64'd0, EW_8);
        send_item(OP_SEQ, 32'd101, 3'd0, 64'd0, EW_8);
        send_item(OP_FIELD_S, 32'd100, 3'd0, 64'd1, EW_8);
        send_item(OP_END, 32'd0, 3'd0, 64'd0, EW_8);
        directed_items = items_sent;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       program_regs(32'hFFFF_FFFF, 3'd6, 3'd7, 1'b0);
                1:       program_regs(32'd0, 3'd0, 3'd0, 1'b0);
                2:       program_regs($urandom, 3'd7, 3'd7, 1'b1);
                3:       program_regs(32'd1000, 3'd7, 3'd0, 1'b0);
                4:       program_regs($urandom_range(32'h000F_FFFF, 1),
                                      CODE_W'($urandom_range(0, 7)),
                                      CODE_W'($urandom_range(0, 7)), 1'b0);
                default: program_regs(32'hFFFF_FFFF, SEQ_START_RESET, SEQ_END_RESET, 1'b0);
            endcase
            open_depth  = 0;
            phase_start = random_items;
            while (random_items - phase_start < RANDOM_PER_PHASE)
            begin
                send_random();
                if (phase == 2 && random_items - phase_start == RANDOM_PER_PHASE / 2)
                    drain_outputs();
            end
        end

        drain_outputs();
        $display("sent %0d items (%0d directed, %0d random) under %0d register settings",
                 items_sent, directed_items, random_items, settings_count);
        $display("checked %0d output transfers, %0d items rejected for their id",
                 beats_checked, rejections);
        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
